[rtl/core/uv_sphere_mesh_generator_assert.svh]
// Assertion macros shared by the sphere mesh RTL.
// Each expects clk and rst in scope.
`ifndef UV_SPHERE_MESH_GENERATOR_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_ASSERT_SVH

// Condition implies consequence in the same cycle
`define UVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uvs assertion failed");

// Condition implies consequence in the next cycle
`define UVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uvs assertion failed");

`endif

[rtl/core/uvs_pkg.sv]
package uvs_pkg;

  // Input transaction
  typedef struct packed {
    logic       func;
    logic [7:0] ring;
    logic [7:0] segment;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        index_value;
    logic               last;
    logic               error;
  } out_item_t;

  // Classified item held in the queue
  typedef struct packed {
    logic       func;
    logic [7:0] ring;
    logic [7:0] segment;
    logic       err;
  } q_item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  localparam logic FUNC_VERTEX = 1'b0;
  localparam logic FUNC_CELL   = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [2:0] LAST_BEAT = 3'd5;

  // Sine core
  localparam int          SIN_LAT     = 16;
  localparam int          NTERMS      = 6;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Exact reciprocals for the Taylor divisors 156, 110, 72, 42, 20, 6 over 32-bit values
  localparam logic [32:0] RECIP [NTERMS] = '{
    33'd7048151461, 33'd4997780127, 33'd7635497416,
    33'd6544712071, 33'd6871947674, 33'd5726623062
  };
  localparam int RSHIFT [NTERMS] = '{40, 39, 39, 38, 37, 35};

endpackage

[rtl/core/uvs_front.sv]
`include "uv_sphere_mesh_generator_assert.svh"

module uvs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         resolution,
  input  logic               in_valid,
  output logic               in_ready,
  input  uvs_pkg::in_item_t  in_data,
  input  logic               pop,
  output uvs_pkg::q_head_t   head
);
  import uvs_pkg::*;

  q_item_t        mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;
  q_item_t        cls;

  assign in_ready = (count != QAW'(0) + (QAW+1)'(QDEPTH));
  assign push     = in_valid && in_ready;

  // Range check against the current resolution
  always_comb begin
    cls.func    = in_data.func;
    cls.ring    = in_data.ring;
    cls.segment = in_data.segment;
    if (in_data.func == FUNC_CELL) begin
      cls.err = (in_data.ring >= resolution) || (in_data.segment >= resolution);
    end else begin
      cls.err = (in_data.ring > resolution) || (in_data.segment >= resolution);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      if (push && !pop) begin
        count <= count + (QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  `UVS_ASSERT_IMP(a_pop_nonempty, pop, count != '0)
  `UVS_ASSERT_NEXT(a_push_grows, push && !pop, count == $past(count) + (QAW+1)'(1))
  `UVS_ASSERT_IMP(a_full_block, count == (QAW+1)'(QDEPTH), !in_ready)

endmodule

[rtl/core/uvs_div.sv]
module uvs_div #(
  parameter int NW = 26,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  // One quotient bit per stage, restoring
  logic [DW-1:0] rem_st [NW];
  logic [NW-1:0] num_st [NW];
  logic [NW-1:0] quo_st [NW];

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_st[s-1];
      assign num_in = num_st[s-1];
      assign quo_in = quo_st[s-1];
    end

    assign trial = {rem_in, num_in[NW-1-s]};
    assign take  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_st[s] <= take ? DW'(trial - {1'b0, den}) : DW'(trial);
        num_st[s] <= num_in;
        quo_st[s] <= {quo_in[NW-2:0], take};
      end
    end
  end

  assign quo = quo_st[NW-1];

endmodule

[rtl/core/uvs_sin.sv]
module uvs_sin #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] code,
  output logic [30:0]           mag,
  output logic                  neg
);
  import uvs_pkg::*;

  localparam int RW = ANGLE_BITS - 1;
  localparam int PW = RW + 31;
  localparam logic [RW-1:0] QUARTER = {1'b1, {(ANGLE_BITS-2){1'b0}}};
  localparam int NS = 2 * NTERMS + 1;

  logic [RW-1:0] r_fold;
  logic          neg_f;
  logic [30:0]   x_s;
  logic          neg_s;
  logic [RW-1:0] r_ext;

  logic [30:0] x_st   [NS];
  logic [31:0] xsq_st [NS];
  logic        neg_st [NS];
  logic [31:0] p_st   [NTERMS];
  logic [30:0] t_st   [1:NTERMS];

  assign r_ext = {1'b0, code[ANGLE_BITS-3:0]};

  // Quadrant fold
  always_ff @(posedge clk) begin
    if (en) begin
      r_fold <= code[ANGLE_BITS-2] ? QUARTER - r_ext : r_ext;
      neg_f  <= code[ANGLE_BITS-1];
    end
  end

  // Angle in radians, Q30
  always_ff @(posedge clk) begin
    if (en) begin
      x_s   <= 31'((PW'(r_fold) * PW'(HALF_PI_Q30)) >> (ANGLE_BITS - 2));
      neg_s <= neg_f;
    end
  end

  // Square of the angle
  always_ff @(posedge clk) begin
    if (en) begin
      x_st[0]   <= x_s;
      xsq_st[0] <= 32'((62'(x_s) * 62'(x_s)) >> 30);
      neg_st[0] <= neg_s;
    end
  end

  // Horner steps, t = 1 - x^2 t / d, two stages each
  for (genvar k = 0; k < NTERMS; k++) begin : g_term
    logic [30:0] t_cur;

    if (k == 0) begin : g_one
      assign t_cur = ONE_Q30;
    end else begin : g_prev
      assign t_cur = t_st[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_st[k]       <= 32'((64'(xsq_st[2*k]) * 64'(t_cur)) >> 30);
        x_st[2*k+1]   <= x_st[2*k];
        xsq_st[2*k+1] <= xsq_st[2*k];
        neg_st[2*k+1] <= neg_st[2*k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_st[k+1]     <= ONE_Q30 - 31'((65'(p_st[k]) * 65'(RECIP[k])) >> RSHIFT[k]);
        x_st[2*k+2]   <= x_st[2*k+1];
        xsq_st[2*k+2] <= xsq_st[2*k+1];
        neg_st[2*k+2] <= neg_st[2*k+1];
      end
    end
  end

  // Final product x * t
  always_ff @(posedge clk) begin
    if (en) begin
      mag <= 31'((62'(x_st[NS-1]) * 62'(t_st[NTERMS])) >> 30);
      neg <= neg_st[NS-1];
    end
  end

endmodule

[rtl/core/uvs_back.sv]
`include "uv_sphere_mesh_generator_assert.svh"

module uvs_back #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         resolution,
  input  uvs_pkg::q_head_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output uvs_pkg::out_item_t out_data
);
  import uvs_pkg::*;

  localparam int NW_A = ANGLE_BITS + 10;
  localparam int NW_F = FRAC_BITS + 11;
  localparam int NW   = (NW_A > NW_F) ? NW_A : NW_F;
  localparam int DW   = 9;
  localparam int D    = NW + SIN_LAT + 2;
  localparam int UVD  = SIN_LAT + 2;
  localparam logic [ANGLE_BITS-1:0] QTURN = {2'b01, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [62:0] HALF_F   = 63'(1) << (FRAC_BITS - 1);
  localparam logic [62:0] ONE_F    = 63'(1) << FRAC_BITS;
  localparam logic [62:0] ONE_F_M1 = ONE_F - 63'd1;

  typedef struct packed {
    logic        valid;
    logic        func;
    logic        err;
    logic [15:0] idx0;
    logic [15:0] idx1;
    logic [15:0] idx2;
    logic [15:0] idx3;
  } sb_t;

  function automatic logic [15:0] round_sat(input logic [61:0] m, input logic neg,
                                            input int sh, input logic [62:0] lim_p,
                                            input logic [62:0] lim_n);
    logic [62:0] r;
    r = ({1'b0, m} + (63'd1 << (sh - 1))) >> sh;
    if (neg) begin
      if (r > lim_n) r = lim_n;
      r = -r;
    end else if (r > lim_p) begin
      r = lim_p;
    end
    return r[15:0];
  endfunction

  logic    adv;
  logic    o_last;
  logic    s1_valid;
  q_item_t s1;

  // Entry stage
  assign pop = adv && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= head.item;
    end
  end

  // Numerators for the four divisions by 2R
  logic [7:0]    kk;
  logic [NW-1:0] th_num, ph_num, u_num, v_num;
  logic [DW-1:0] den;

  assign kk     = (s1.segment <= (resolution >> 1)) ? s1.segment : resolution - s1.segment;
  assign den    = {resolution, 1'b0};
  assign th_num = (NW'(s1.ring) << ANGLE_BITS) + NW'(resolution);
  assign ph_num = (NW'(s1.segment) << (ANGLE_BITS + 1)) + NW'(resolution);
  assign u_num  = (NW'(kk) << (FRAC_BITS + 2)) + NW'(resolution);
  assign v_num  = (NW'(resolution - s1.ring) << (FRAC_BITS + 1)) + NW'(resolution);

  // Cell indices
  logic [15:0] i_r, i1_r;
  logic [7:0]  jn;
  sb_t         sb_in;

  assign i_r  = 16'(s1.ring) * 16'(resolution);
  assign i1_r = i_r + 16'(resolution);
  assign jn   = (9'(s1.segment) + 9'd1 == 9'(resolution)) ? 8'd0 : s1.segment + 8'd1;

  always_comb begin
    sb_in.valid = s1_valid;
    sb_in.func  = s1.func;
    sb_in.err   = s1.err;
    sb_in.idx0  = i_r + 16'(s1.segment);
    sb_in.idx1  = i1_r + 16'(s1.segment);
    sb_in.idx2  = i_r + 16'(jn);
    sb_in.idx3  = i1_r + 16'(jn);
  end

  // Sideband delay line, matched to the arithmetic
  sb_t sb [D];

  for (genvar n = 0; n < D; n++) begin : g_sb
    always_ff @(posedge clk) begin
      if (rst) begin
        sb[n].valid <= 1'b0;
      end else if (adv) begin
        if (n == 0) sb[n] <= sb_in;
        else        sb[n] <= sb[(n == 0) ? 0 : n-1];
      end
    end
  end

  // Dividers
  logic [NW-1:0] th_q, ph_q, u_q, v_q;

  uvs_div #(.NW(NW), .DW(DW)) u_div_th (.clk, .en(adv), .num(th_num), .den, .quo(th_q));
  uvs_div #(.NW(NW), .DW(DW)) u_div_ph (.clk, .en(adv), .num(ph_num), .den, .quo(ph_q));
  uvs_div #(.NW(NW), .DW(DW)) u_div_u  (.clk, .en(adv), .num(u_num),  .den, .quo(u_q));
  uvs_div #(.NW(NW), .DW(DW)) u_div_v  (.clk, .en(adv), .num(v_num),  .den, .quo(v_q));

  // Sine and cosine of both angles
  logic [30:0] st_m, ct_m, sp_m, cp_m;
  logic        st_n, ct_n, sp_n, cp_n;

  uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_st (.clk, .en(adv),
    .code(th_q[ANGLE_BITS-1:0]), .mag(st_m), .neg(st_n));
  uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_ct (.clk, .en(adv),
    .code(th_q[ANGLE_BITS-1:0] + QTURN), .mag(ct_m), .neg(ct_n));
  uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_sp (.clk, .en(adv),
    .code(ph_q[ANGLE_BITS-1:0]), .mag(sp_m), .neg(sp_n));
  uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_cp (.clk, .en(adv),
    .code(ph_q[ANGLE_BITS-1:0] + QTURN), .mag(cp_m), .neg(cp_n));

  // Texture coordinates wait for the trig
  logic [15:0] u_d [UVD];
  logic [15:0] v_d [UVD];

  for (genvar n = 0; n < UVD; n++) begin : g_uv
    always_ff @(posedge clk) begin
      if (adv) begin
        if (n == 0) begin
          u_d[n] <= u_q[15:0];
          v_d[n] <= v_q[15:0];
        end else begin
          u_d[n] <= u_d[(n == 0) ? 0 : n-1];
          v_d[n] <= v_d[(n == 0) ? 0 : n-1];
        end
      end
    end
  end

  // Normal products in Q60
  logic [61:0] prod     [3];
  logic        prod_neg [3];
  logic [15:0] pos_r    [3];
  logic [15:0] nrm_r    [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      prod[0]     <= 62'(st_m) * 62'(sp_m);
      prod_neg[0] <= st_n ^ sp_n;
      prod[1]     <= 62'({ct_m, 30'd0});
      prod_neg[1] <= ct_n;
      prod[2]     <= 62'(st_m) * 62'(cp_m);
      prod_neg[2] <= st_n ^ cp_n;
    end
  end

  // Round to position and normal formats
  for (genvar a = 0; a < 3; a++) begin : g_rnd
    always_ff @(posedge clk) begin
      if (adv) begin
        pos_r[a] <= round_sat(prod[a], prod_neg[a], 61 - FRAC_BITS, HALF_F, HALF_F);
        nrm_r[a] <= round_sat(prod[a], prod_neg[a], 60 - FRAC_BITS, ONE_F_M1, ONE_F);
      end
    end
  end

  // Output register and cell beat counter
  logic        o_valid;
  logic        o_func;
  logic        o_err;
  logic [2:0]  cnt;
  logic [15:0] o_idx0, o_idx1, o_idx2, o_idx3;
  logic [15:0] o_pos [3];
  logic [15:0] o_nrm [3];
  logic [15:0] o_u, o_v;
  logic [15:0] idx_sel;

  assign o_last = o_err || (o_func == FUNC_VERTEX) || (cnt == LAST_BEAT);
  assign adv    = !o_valid || (out_ready && o_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      cnt     <= '0;
    end else if (adv) begin
      o_valid <= sb[D-1].valid;
      cnt     <= '0;
    end else if (out_ready) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_func <= sb[D-1].func;
      o_err  <= sb[D-1].err;
      o_idx0 <= sb[D-1].idx0;
      o_idx1 <= sb[D-1].idx1;
      o_idx2 <= sb[D-1].idx2;
      o_idx3 <= sb[D-1].idx3;
      o_pos  <= pos_r;
      o_nrm  <= nrm_r;
      o_u    <= u_d[UVD-1];
      o_v    <= v_d[UVD-1];
    end
  end

  // Triangle order idx0 idx1 idx2 idx2 idx1 idx3
  always_comb begin
    case (cnt)
      3'd0:    idx_sel = o_idx0;
      3'd1:    idx_sel = o_idx1;
      3'd2:    idx_sel = o_idx2;
      3'd3:    idx_sel = o_idx2;
      3'd4:    idx_sel = o_idx1;
      3'd5:    idx_sel = o_idx3;
      default: idx_sel = '0;
    endcase
  end

  always_comb begin
    out_data = '0;
    if (o_err) begin
      out_data.error = 1'b1;
      out_data.last  = 1'b1;
    end else if (o_func == FUNC_CELL) begin
      out_data.index_value = idx_sel;
      out_data.last        = (cnt == LAST_BEAT);
    end else begin
      out_data.pos_x = o_pos[0];
      out_data.pos_y = o_pos[1];
      out_data.pos_z = o_pos[2];
      out_data.nrm_x = o_nrm[0];
      out_data.nrm_y = o_nrm[1];
      out_data.nrm_z = o_nrm[2];
      out_data.tex_u = o_u;
      out_data.tex_v = o_v;
      out_data.last  = 1'b1;
    end
  end

  assign out_valid = o_valid;

  `UVS_ASSERT_IMP(a_err_last, out_valid && out_data.error, out_data.last)
  `UVS_ASSERT_IMP(a_beat_cell, o_valid && cnt != '0, o_func == FUNC_CELL && !o_err)
  `UVS_ASSERT_NEXT(a_cell_cont, out_valid && out_ready && !out_data.last, out_valid)

endmodule

[rtl/core/uv_sphere_mesh_generator.sv]
// UV sphere mesh generator.
// Input channel in_valid/in_ready/in_data: func 0 evaluates the vertex at
// (ring, segment), func 1 emits the six triangle indices of a cell.
// Output channel out_valid/out_ready/out_data: one transaction per vertex,
// six per cell (last marks the final one), one with error set for an
// item out of range.
// resolution_we/resolution_data write R (0 taken as 1, capped at
// MAX_RESOLUTION); write only while the block is idle.
// The path is a four-entry queue, a restoring divider with one quotient
// bit per stage (NW stages, NW = max(ANGLE_BITS + 10, FRAC_BITS + 11),
// 26 by default), the 16-stage sine core, product and rounding stages
// and the output register.
// Throughput: one vertex per cycle while out_ready is high; a cell holds
// the output for its six index transactions. When out_ready is low and
// an output is held, the back pipeline freezes; the queue keeps taking
// input until four items wait.
// Reset (rst, synchronous) empties the queue and pipeline and sets R to 32.
module uv_sphere_mesh_generator #(
  parameter int MAX_RESOLUTION = 255,
  parameter int ANGLE_BITS     = 16,
  parameter int FRAC_BITS      = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  uvs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output uvs_pkg::out_item_t out_data,
  input  logic               resolution_we,
  input  logic [7:0]         resolution_data
);
  import uvs_pkg::*;

  localparam logic [7:0] RES_MAX   = 8'(MAX_RESOLUTION);
  localparam logic [7:0] RES_RESET = 8'd32;

  logic [7:0] resolution;
  q_head_t    head;
  logic       pop;

  // Resolution register with saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= RES_RESET;
    end else if (resolution_we) begin
      if (resolution_data == 8'd0) begin
        resolution <= 8'd1;
      end else if (resolution_data > RES_MAX) begin
        resolution <= RES_MAX;
      end else begin
        resolution <= resolution_data;
      end
    end
  end

  uvs_front u_front (
    .clk,
    .rst,
    .resolution,
    .in_valid,
    .in_ready,
    .in_data,
    .pop,
    .head
  );

  uvs_back #(
    .ANGLE_BITS(ANGLE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk,
    .rst,
    .resolution,
    .head,
    .pop,
    .out_valid,
    .out_ready,
    .out_data
  );

endmodule
